// ----- design/b32h_pkg.sv -----
package b32h_pkg;

    localparam int unsigned GROUP_BITS       = 5;
    localparam int unsigned GROUPS_PER_JOB   = 3;
    localparam int unsigned MIN_CHARS        = 5;
    localparam int unsigned CHAR_COUNT_RESET = 26;
    localparam int unsigned CFG_WIDTH        = 11;
    localparam int unsigned CODE_WIDTH       = 7;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam logic [CODE_WIDTH-1:0] ASCII_DIGIT_BASE  = 7'd48;
    localparam logic [CODE_WIDTH-1:0] ASCII_LETTER_BASE = 7'd87;

    typedef logic [GROUP_BITS-1:0] t_group;

    // Groups of one byte step, first group in entry 0, with their count and end flag.
    typedef struct packed {
        t_group [GROUPS_PER_JOB-1:0] groups;
        logic   [1:0]                n_groups;
        logic                        fin;
    } t_job;

    function automatic logic [CODE_WIDTH-1:0] group_to_char(input t_group g);
        logic [CODE_WIDTH-1:0] v;
        v = {2'b00, g};
        if (g < 5'd10) begin
            group_to_char = ASCII_DIGIT_BASE + v;
        end else begin
            group_to_char = ASCII_LETTER_BASE + v;
        end
    endfunction

endpackage

// ----- design/b32h_if.sv -----
interface b32h_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source(output valid, output data_byte, output final_byte, input ready);
    modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32h_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;
    modport source(output valid, output char_code, output last_char, input ready);
    modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface b32h_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] char_count;
    modport source(output valid, output char_count, input ready);
    modport sink(input valid, input char_count, output ready);
endinterface

// ----- design/b32h_front.sv -----
module b32h_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    b32h_byte_if.sink          i_in,
    input  logic               i_full,
    output logic               o_push,
    output b32h_pkg::t_job     o_job
);

    logic [3:0]  r_left_bits;
    logic [2:0]  r_left_cnt;
    logic [3:0]  n_left_bits;
    logic [2:0]  n_left_cnt;
    logic [11:0] w_buf;
    logic [11:0] w_align;
    logic [14:0] w_window;
    logic        w_two;
    logic [2:0]  w_rem;
    logic [3:0]  w_mask;
    logic        w_pad;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        w_buf    = {r_left_bits, i_in.data_byte};
        w_align  = w_buf << (3'd4 - r_left_cnt);
        w_window = {w_align, 3'b000};
        w_two    = (r_left_cnt >= 3'd2);
        w_rem    = w_two ? (r_left_cnt - 3'd2) : (r_left_cnt + 3'd3);
        w_mask   = (4'd1 << w_rem) - 4'd1;
        w_pad    = i_in.final_byte && (w_rem != 3'd0);

        o_job.groups[0] = w_window[14:10];
        o_job.groups[1] = w_window[9:5];
        o_job.groups[2] = w_window[4:0];
        o_job.n_groups  = (w_two ? 2'd2 : 2'd1) + {1'b0, w_pad};
        o_job.fin       = i_in.final_byte;

        if (i_in.final_byte) begin
            n_left_bits = 4'd0;
            n_left_cnt  = 3'd0;
        end else begin
            n_left_bits = w_buf[3:0] & w_mask;
            n_left_cnt  = w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits <= 4'd0;
            r_left_cnt  <= 3'd0;
        end else if (o_push) begin
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
        end
    end

endmodule

// ----- design/b32h_queue.sv -----
module b32h_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b32h_pkg::t_job     i_job,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output b32h_pkg::t_job     o_head
);

    localparam int unsigned AW = $clog2(b32h_pkg::QUEUE_DEPTH);

    b32h_pkg::t_job r_mem [b32h_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;

    assign o_full  = (r_count == (AW+1)'(b32h_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

// ----- design/b32h_back.sv -----
module b32h_back #(
    parameter int unsigned CW = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b32h_pkg::t_job     i_job,
    input  logic               i_empty,
    input  logic [CW-1:0]      i_limit,
    output logic               o_pop,
    b32h_char_if.source        o_out
);

    logic [1:0]    r_idx;
    logic [CW-1:0] r_emit;
    logic          r_valid;
    logic [6:0]    r_code;
    logic          r_last;
    logic          w_adv;
    logic          w_take;
    logic          w_keep;
    logic          w_end;

    assign w_adv  = !r_valid || o_out.ready;
    assign w_take = w_adv && !i_empty;
    assign w_keep = (r_emit < i_limit);
    assign w_end  = (r_idx == (i_job.n_groups - 2'd1));
    assign o_pop  = w_take && w_end;

    assign o_out.valid     = r_valid;
    assign o_out.char_code = r_code;
    assign o_out.last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_code <= b32h_pkg::group_to_char(i_job.groups[r_idx]);
            r_last <= ((r_emit + CW'(1)) == i_limit) || (i_job.fin && w_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_emit  <= '0;
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= w_take && w_keep;
            if (w_take) begin
                if (w_end) begin
                    r_idx <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
                if (w_end && i_job.fin) begin
                    r_emit <= '0;
                end else if (w_keep) begin
                    r_emit <= r_emit + CW'(1);
                end
            end
        end
    end

endmodule

// ----- design/base32hex_byte_encoder_unit.sv -----
// Channel  Direction  Handshake        Word
// i_in     in         valid / ready    data_byte[7:0], final_byte
// o_out    out        valid / ready    char_code[6:0], last_char
// i_cfg    in         valid / ready    char_count[10:0]
// Each byte yields one or two characters, three with the final padding, one per cycle while o_out is ready.
// The character stage sets the rate on a long string.
// A two-entry queue decouples byte intake from character output, so bytes keep
// arriving while a character waits on o_out.ready, until the queue fills.
// Synchronous active-low reset clears the queue, the bit carry and the counters.
module base32hex_byte_encoder_unit #(
    parameter int unsigned MAX_CHARS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b32h_byte_if.sink    i_in,
    b32h_cfg_if.sink     i_cfg,
    b32h_char_if.source  o_out
);

    localparam int unsigned CW = $clog2(MAX_CHARS + 1);
    localparam int unsigned RESET_LIMIT =
        (b32h_pkg::CHAR_COUNT_RESET > MAX_CHARS) ? MAX_CHARS : b32h_pkg::CHAR_COUNT_RESET;

    logic [CW-1:0]  r_limit;
    logic [CW-1:0]  n_limit;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    b32h_pkg::t_job w_job_in;
    b32h_pkg::t_job w_job_head;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (i_cfg.char_count < 11'(b32h_pkg::MIN_CHARS)) begin
            n_limit = CW'(b32h_pkg::MIN_CHARS);
        end else if (i_cfg.char_count > 11'(MAX_CHARS)) begin
            n_limit = CW'(MAX_CHARS);
        end else begin
            n_limit = CW'(i_cfg.char_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CW'(RESET_LIMIT);
        end else if (i_cfg.valid) begin
            r_limit <= n_limit;
        end
    end

    b32h_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    b32h_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_job_head)
    );

    b32h_back #(
        .CW (CW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_head),
        .i_empty (w_empty),
        .i_limit (r_limit),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
